>>> sv/mask_pixel_format_converter_core_defines.svh
`ifndef MASK_PIXEL_FORMAT_CONVERTER_CORE_DEFINES_SVH
`define MASK_PIXEL_FORMAT_CONVERTER_CORE_DEFINES_SVH

// Same-cycle implication on clk, ignored while rst_n is low
`define MPFC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on clk, ignored while rst_n is low
`define MPFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/mpfc_pkg.sv
package mpfc_pkg;

    localparam int unsigned PixelWidth   = 32;
    localparam int unsigned ChanWidth    = 8;
    localparam int unsigned ShiftWidth   = 5;
    localparam int unsigned FieldWidth   = 6;
    localparam int unsigned CfgIdxWidth  = 2;
    localparam int unsigned DataWidth    = PixelWidth + 3 * ChanWidth;

    localparam logic [CfgIdxWidth-1:0] CFG_RED_MASK    = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_GREEN_MASK  = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_BLUE_MASK   = 2'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_SHORT_PIXEL = 2'd3;

    localparam logic [PixelWidth-1:0] RED_MASK_RST   = 32'h00FF_0000;
    localparam logic [PixelWidth-1:0] GREEN_MASK_RST = 32'h0000_FF00;
    localparam logic [PixelWidth-1:0] BLUE_MASK_RST  = 32'h0000_00FF;

    localparam logic CMD_UNPACK = 1'b0;
    localparam logic CMD_PACK   = 1'b1;

    typedef struct packed {
        logic [ShiftWidth-1:0] shift;
        logic [FieldWidth-1:0] width;
    } geom_t;

    localparam geom_t RED_GEOM_RST   = '{shift: 5'd16, width: 6'd8};
    localparam geom_t GREEN_GEOM_RST = '{shift: 5'd8,  width: 6'd8};
    localparam geom_t BLUE_GEOM_RST  = '{shift: 5'd0,  width: 6'd8};

    // trailing zero count, zero for an empty mask
    function automatic logic [ShiftWidth-1:0] mask_shift(input logic [PixelWidth-1:0] m);
        logic [ShiftWidth-1:0] n;
        n = '0;
        for (int i = PixelWidth - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                n = ShiftWidth'(i);
            end
        end
        return n;
    endfunction

    // length of the run of ones from the highest set bit downward
    function automatic logic [FieldWidth-1:0] mask_width(input logic [PixelWidth-1:0] m);
        logic [FieldWidth-1:0] top_plus;
        logic [FieldWidth-1:0] gap_plus;
        top_plus = '0;
        gap_plus = '0;
        for (int i = 0; i < PixelWidth; i++)
        begin
            if (m[i])
            begin
                top_plus = FieldWidth'(i + 1);
            end
        end
        for (int i = 0; i < PixelWidth; i++)
        begin
            if (!m[i] && (FieldWidth'(i + 1) < top_plus))
            begin
                gap_plus = FieldWidth'(i + 1);
            end
        end
        return top_plus - gap_plus;
    endfunction

    function automatic geom_t mask_geom(input logic [PixelWidth-1:0] m);
        geom_t g;
        g.shift = mask_shift(m);
        g.width = mask_width(m);
        return g;
    endfunction

endpackage

>>> sv/mpfc_chan.sv
module mpfc_chan
(
    input  logic [mpfc_pkg::PixelWidth-1:0] mask,
    input  mpfc_pkg::geom_t                 geom,
    input  logic                            short_pixel,
    input  logic [mpfc_pkg::PixelWidth-1:0] pixel,
    input  logic [mpfc_pkg::ChanWidth-1:0]  chan_in,
    output logic [mpfc_pkg::ChanWidth-1:0]  unpacked,
    output logic [mpfc_pkg::PixelWidth-1:0] packed_field
);

    logic [mpfc_pkg::PixelWidth-1:0] field;
    logic [mpfc_pkg::ChanWidth-1:0]  sat;
    logic [3:0]                      drop;
    logic [mpfc_pkg::ChanWidth-1:0]  trimmed;

    assign field = (pixel & mask) >> geom.shift;
    assign sat   = (|field[mpfc_pkg::PixelWidth-1:mpfc_pkg::ChanWidth]) ? 8'hFF
                                                                        : field[7:0];
    assign unpacked = short_pixel ? {sat[4:0], 3'b000} : sat;

    always_comb
    begin
        drop    = 4'd8 - {1'b0, geom.width[2:0]};
        trimmed = chan_in;
        if (geom.width < 6'd8)
        begin
            trimmed = chan_in >> drop;
        end
    end

    assign packed_field = mpfc_pkg::PixelWidth'(trimmed) << geom.shift;

endmodule

>>> sv/mask_pixel_format_converter_core.sv
// A transaction passes from the input registers to the result registers, which drive m_tvalid.
// Throughput: one transaction per cycle while results are taken; a stalled result is held while one more is taken in.
// Geometry (shift, width) of each mask is registered together with the mask on a write.
// Reset (rst_n, asynchronous, active low) empties both stages and restores the
// 8:8:8 layout at bits 23:16, 15:8, 7:0 with short pixel mode off.
`include "mask_pixel_format_converter_core_defines.svh"

module mask_pixel_format_converter_core
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mpfc_pkg::DataWidth-1:0]      s_tdata,  // pixel_in, red_in, green_in, blue_in
    input  logic                                s_tuser,  // command

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mpfc_pkg::DataWidth-1:0]      m_tdata,  // pixel_out, red_out, green_out, blue_out

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mpfc_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  logic [mpfc_pkg::PixelWidth-1:0]     cfg_data
);

    logic [mpfc_pkg::PixelWidth-1:0] red_mask_reg;
    logic [mpfc_pkg::PixelWidth-1:0] green_mask_reg;
    logic [mpfc_pkg::PixelWidth-1:0] blue_mask_reg;
    logic                            short_pixel_reg;
    mpfc_pkg::geom_t                 red_geom_reg;
    mpfc_pkg::geom_t                 green_geom_reg;
    mpfc_pkg::geom_t                 blue_geom_reg;

    logic                            in_valid_reg;
    logic                            in_cmd_reg;
    logic [mpfc_pkg::DataWidth-1:0]  in_data_reg;
    logic                            out_valid_reg;
    logic [mpfc_pkg::DataWidth-1:0]  out_data_reg;
    logic [mpfc_pkg::DataWidth-1:0]  out_data_next;

    logic                            advance;
    logic                            in_take;
    logic                            cfg_take;

    logic [mpfc_pkg::PixelWidth-1:0] pixel_in;
    logic [mpfc_pkg::ChanWidth-1:0]  red_unp;
    logic [mpfc_pkg::ChanWidth-1:0]  green_unp;
    logic [mpfc_pkg::ChanWidth-1:0]  blue_unp;
    logic [mpfc_pkg::PixelWidth-1:0] red_pk;
    logic [mpfc_pkg::PixelWidth-1:0] green_pk;
    logic [mpfc_pkg::PixelWidth-1:0] blue_pk;

    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid && cfg_ready;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_mask_reg    <= mpfc_pkg::RED_MASK_RST;
            green_mask_reg  <= mpfc_pkg::GREEN_MASK_RST;
            blue_mask_reg   <= mpfc_pkg::BLUE_MASK_RST;
            short_pixel_reg <= 1'b0;
            red_geom_reg    <= mpfc_pkg::RED_GEOM_RST;
            green_geom_reg  <= mpfc_pkg::GREEN_GEOM_RST;
            blue_geom_reg   <= mpfc_pkg::BLUE_GEOM_RST;
        end
        else
        begin
            if (cfg_take)
            begin
                case (cfg_index)
                    mpfc_pkg::CFG_RED_MASK:
                    begin
                        red_mask_reg <= cfg_data;
                        red_geom_reg <= mpfc_pkg::mask_geom(cfg_data);
                    end
                    mpfc_pkg::CFG_GREEN_MASK:
                    begin
                        green_mask_reg <= cfg_data;
                        green_geom_reg <= mpfc_pkg::mask_geom(cfg_data);
                    end
                    mpfc_pkg::CFG_BLUE_MASK:
                    begin
                        blue_mask_reg <= cfg_data;
                        blue_geom_reg <= mpfc_pkg::mask_geom(cfg_data);
                    end
                    mpfc_pkg::CFG_SHORT_PIXEL: short_pixel_reg <= cfg_data[0];
                    default:                   short_pixel_reg <= short_pixel_reg;
                endcase
            end
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg  <= s_tuser;
            in_data_reg <= s_tdata;
        end
    end

    assign pixel_in = in_data_reg[31:0];

    mpfc_chan u_red
    (
        .mask         (red_mask_reg),
        .geom         (red_geom_reg),
        .short_pixel  (short_pixel_reg),
        .pixel        (pixel_in),
        .chan_in      (in_data_reg[39:32]),
        .unpacked     (red_unp),
        .packed_field (red_pk)
    );

    mpfc_chan u_green
    (
        .mask         (green_mask_reg),
        .geom         (green_geom_reg),
        .short_pixel  (short_pixel_reg),
        .pixel        (pixel_in),
        .chan_in      (in_data_reg[47:40]),
        .unpacked     (green_unp),
        .packed_field (green_pk)
    );

    mpfc_chan u_blue
    (
        .mask         (blue_mask_reg),
        .geom         (blue_geom_reg),
        .short_pixel  (short_pixel_reg),
        .pixel        (pixel_in),
        .chan_in      (in_data_reg[55:48]),
        .unpacked     (blue_unp),
        .packed_field (blue_pk)
    );

    always_comb
    begin
        case (in_cmd_reg)
            mpfc_pkg::CMD_PACK:   out_data_next = {24'd0, red_pk | green_pk | blue_pk};
            mpfc_pkg::CMD_UNPACK: out_data_next = {blue_unp, green_unp, red_unp, 32'd0};
            default:              out_data_next = '0;
        endcase
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    `MPFC_ASSERT_IMPL(a_stall_only_when_full, !s_tready, in_valid_reg && out_valid_reg,
                      "input stalled with a free stage")
    `MPFC_ASSERT_NEXT(a_input_stage_holds, in_valid_reg && !advance,
                      in_valid_reg && $stable(in_data_reg),
                      "held transaction lost from input stage")
    `MPFC_ASSERT_IMPL(a_result_one_kind, out_valid_reg && (out_data_reg[55:32] != 24'd0),
                      out_data_reg[31:0] == 32'd0, "result carries both pixel and channels")
    `MPFC_ASSERT_NEXT(a_geom_follows_mask, cfg_take && (cfg_index == mpfc_pkg::CFG_RED_MASK),
                      red_geom_reg == mpfc_pkg::mask_geom($past(cfg_data)),
                      "red geometry out of step with mask")

endmodule

>>> dv/tb_mask_pixel_format_converter_core.sv
module tb_mask_pixel_format_converter_core;

    import mpfc_pkg::*;

    typedef struct {
        logic                  cmd;
        logic [PixelWidth-1:0] pixel;
        logic [ChanWidth-1:0]  red;
        logic [ChanWidth-1:0]  green;
        logic [ChanWidth-1:0]  blue;
    } pixel_job_t;

    typedef struct {
        logic [PixelWidth-1:0] pixel;
        logic [ChanWidth-1:0]  red;
        logic [ChanWidth-1:0]  green;
        logic [ChanWidth-1:0]  blue;
    } converted_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [DataWidth-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [DataWidth-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CfgIdxWidth-1:0] cfg_index = '0;
    logic [PixelWidth-1:0]  cfg_data = '0;

    logic [PixelWidth-1:0]  red_layout = RED_MASK_RST;
    logic [PixelWidth-1:0]  green_layout = GREEN_MASK_RST;
    logic [PixelWidth-1:0]  blue_layout = BLUE_MASK_RST;
    logic                   short_mode = 1'b0;

    pixel_job_t  pixel_jobs[$];
    converted_t  converted_q[$];
    pixel_job_t  offered_job;
    int unsigned tx_gap = 0;
    int unsigned rx_gap = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned error_count = 0;

    mask_pixel_format_converter_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int unsigned low_zero_run(input logic [PixelWidth-1:0] m);
        int unsigned n;
        bit          found;
        n = 0;
        found = 1'b0;
        for (int i = 0; i < PixelWidth; i++)
        begin
            if (m[i] && !found)
            begin
                n = i;
                found = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic int unsigned top_run_len(input logic [PixelWidth-1:0] m);
        int unsigned n;
        bit          seen;
        bit          ended;
        n = 0;
        seen = 1'b0;
        ended = 1'b0;
        for (int i = PixelWidth - 1; i >= 0; i--)
        begin
            if (m[i] && !ended)
            begin
                seen = 1'b1;
                n++;
            end
            else if (seen)
            begin
                ended = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [ChanWidth-1:0] extract_channel(input logic [PixelWidth-1:0] pix,
                                                             input logic [PixelWidth-1:0] m);
        logic [PixelWidth-1:0] v;
        if (m == '0)
        begin
            return '0;
        end
        v = (pix & m) >> low_zero_run(m);
        if (v > 32'd255)
        begin
            v = 32'd255;
        end
        if (short_mode)
        begin
            v = v << 3;
        end
        return v[ChanWidth-1:0];
    endfunction

    function automatic logic [PixelWidth-1:0] place_channel(input logic [ChanWidth-1:0] c,
                                                            input logic [PixelWidth-1:0] m);
        int unsigned  w;
        logic [63:0]  v;
        if (m == '0)
        begin
            return '0;
        end
        w = top_run_len(m);
        v = {56'd0, c};
        if (w < ChanWidth)
        begin
            v = v >> (ChanWidth - w);
        end
        v = v << low_zero_run(m);
        return v[PixelWidth-1:0];
    endfunction

    function automatic converted_t convert_pixel(input pixel_job_t job);
        converted_t r;
        r.pixel = '0;
        r.red = '0;
        r.green = '0;
        r.blue = '0;
        if (job.cmd == CMD_UNPACK)
        begin
            r.red = extract_channel(job.pixel, red_layout);
            r.green = extract_channel(job.pixel, green_layout);
            r.blue = extract_channel(job.pixel, blue_layout);
        end
        else
        begin
            r.pixel = place_channel(job.red, red_layout) | place_channel(job.green, green_layout)
                    | place_channel(job.blue, blue_layout);
        end
        return r;
    endfunction

    function automatic int unsigned idle_len(input bit enabled);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ChanWidth-1:0] pick_channel();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k == 0)
        begin
            return '0;
        end
        if (k == 1)
        begin
            return '1;
        end
        return ChanWidth'($urandom);
    endfunction

    function automatic logic [PixelWidth-1:0] pick_mask();
        int unsigned k;
        int unsigned lo;
        int unsigned len;
        logic [63:0] run;
        k = $urandom_range(0, 9);
        lo = $urandom_range(0, 31);
        len = $urandom_range(1, 12);
        run = ((64'd1 << len) - 64'd1) << lo;
        case (k)
            0: return '0;
            1: return '1;
            2, 3: return $urandom;
            default: return run[PixelWidth-1:0];
        endcase
    endfunction

    task automatic push_job(input logic cmd, input logic [PixelWidth-1:0] pixel,
                            input logic [ChanWidth-1:0] red, input logic [ChanWidth-1:0] green,
                            input logic [ChanWidth-1:0] blue);
        pixel_job_t job;
        job.cmd = cmd;
        job.pixel = pixel;
        job.red = red;
        job.green = green;
        job.blue = blue;
        pixel_jobs.push_back(job);
    endtask

    task automatic push_random_jobs(input int unsigned count);
        int unsigned k;
        logic [PixelWidth-1:0] pix;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(0, 9);
            pix = (k == 0) ? '0 : (k == 1) ? '1 : PixelWidth'($urandom);
            push_job(1'($urandom_range(0, 1)), pix, pick_channel(), pick_channel(),
                     pick_channel());
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pixel_jobs.size() != 0 || s_tvalid || converted_q.size() != 0);
    endtask

    task automatic write_register(input logic [CfgIdxWidth-1:0] idx,
                                  input logic [PixelWidth-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_RED_MASK:    red_layout = value;
            CFG_GREEN_MASK:  green_layout = value;
            CFG_BLUE_MASK:   blue_layout = value;
            CFG_SHORT_PIXEL: short_mode = value[0];
            default:         ;
        endcase
    endtask

    task automatic set_layout(input logic [PixelWidth-1:0] red, input logic [PixelWidth-1:0] green,
                              input logic [PixelWidth-1:0] blue, input logic [PixelWidth-1:0] mode);
        @(posedge clk);
        write_register(CFG_RED_MASK, red);
        write_register(CFG_GREEN_MASK, green);
        write_register(CFG_BLUE_MASK, blue);
        write_register(CFG_SHORT_PIXEL, mode);
        cfg_valid <= 1'b0;
        repeat (4) @(negedge clk);
    endtask

    task automatic check_result(input logic [DataWidth-1:0] d);
        converted_t want;
        if (converted_q.size() == 0)
        begin
            $error("unexpected result transaction: %h", d);
            error_count++;
            return;
        end
        want = converted_q.pop_front();
        if (d[31:0] !== want.pixel)
        begin
            $error("pixel_out expected %h actual %h", want.pixel, d[31:0]);
            error_count++;
        end
        if (d[39:32] !== want.red)
        begin
            $error("red_out expected %h actual %h", want.red, d[39:32]);
            error_count++;
        end
        if (d[47:40] !== want.green)
        begin
            $error("green_out expected %h actual %h", want.green, d[47:40]);
            error_count++;
        end
        if (d[55:48] !== want.blue)
        begin
            $error("blue_out expected %h actual %h", want.blue, d[55:48]);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                converted_q.push_back(convert_pixel(offered_job));
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pixel_jobs.size() != 0)
                begin
                    offered_job = pixel_jobs.pop_front();
                    s_tdata <= {offered_job.blue, offered_job.green, offered_job.red,
                                offered_job.pixel};
                    s_tuser <= offered_job.cmd;
                    s_tvalid <= 1'b1;
                    tx_gap = idle_len(tx_idle_on);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_result(m_tdata);
            end
            if (hold_requests != hold_served)
            begin
                hold_served = hold_requests;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                rx_gap = idle_len(rx_idle_on);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(negedge clk);

        // default 8:8:8 layout
        push_job(CMD_UNPACK, 32'h0000_0000, 8'h00, 8'h00, 8'h00);
        push_job(CMD_UNPACK, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
        push_job(CMD_UNPACK, 32'h1234_5678, 8'h5A, 8'hA5, 8'h3C);
        push_job(CMD_PACK, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00);
        push_job(CMD_PACK, 32'h0000_0000, 8'hFF, 8'hFF, 8'hFF);
        push_job(CMD_PACK, 32'hDEAD_BEEF, 8'h12, 8'h34, 8'h56);
        push_job(CMD_PACK, 32'h5555_5555, 8'h80, 8'h01, 8'hAA);
        push_job(CMD_UNPACK, 32'hAAAA_AAAA, 8'h55, 8'h55, 8'h55);
        wait_drained();

        // 5:6:5 short pixels
        set_layout(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 32'd1);
        push_job(CMD_UNPACK, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00);
        push_job(CMD_UNPACK, 32'h0000_A5A5, 8'h00, 8'h00, 8'h00);
        push_job(CMD_PACK, 32'h0000_0000, 8'hFF, 8'hFF, 8'hFF);
        push_job(CMD_PACK, 32'h0000_0000, 8'h07, 8'h03, 8'hF8);
        push_random_jobs(120);
        wait_drained();

        // empty mask, wide channel that saturates, one-bit field at bit 31
        set_layout(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'd0);
        push_job(CMD_UNPACK, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00);
        push_job(CMD_UNPACK, 32'h0000_00C8, 8'h00, 8'h00, 8'h00);
        push_job(CMD_UNPACK, 32'h8000_0000, 8'h00, 8'h00, 8'h00);
        push_job(CMD_PACK, 32'h0000_0000, 8'hFF, 8'hFF, 8'hFF);
        push_job(CMD_PACK, 32'h0000_0000, 8'hFF, 8'hC3, 8'h7F);
        push_random_jobs(120);
        wait_drained();

        // split masks, with a long receiver hold-off so the input backs up
        set_layout(32'h0F0F_0000, 32'h0000_0F0F, 32'hF000_0001, 32'd1);
        hold_requests++;
        push_job(CMD_UNPACK, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00);
        push_job(CMD_PACK, 32'h0000_0000, 8'hFF, 8'hFF, 8'hFF);
        push_random_jobs(120);
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            set_layout(pick_mask(), pick_mask(), pick_mask(), $urandom);
            tx_idle_on = (p != 2) && (p != 5);
            rx_idle_on = (p != 2) && (p != 6);
            if (p == 4)
            begin
                hold_requests++;
            end
            push_random_jobs(130);
            wait_drained();
        end

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        set_layout(RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST, 32'd0);
        push_random_jobs(30);
        wait_drained();

        repeat (10) @(negedge clk);
        if (converted_q.size() != 0)
        begin
            $error("%0d results never arrived", converted_q.size());
            error_count++;
        end
        if (error_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> mask_pixel_format_converter_core.f
+incdir+sv
sv/mpfc_pkg.sv
sv/mpfc_chan.sv
sv/mask_pixel_format_converter_core.sv
dv/tb_mask_pixel_format_converter_core.sv
